// ----- hw/rtl/q2e_pkg.sv -----
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, angle constants, CORDIC table and field helpers.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int QUAT_WIDTH_DEF = 16;
  localparam int NORM_W         = 16;
  localparam int PROD_W         = 32;
  localparam int CW             = 44;
  localparam int ZW             = 26;
  localparam int STEPS          = 20;
  localparam int PRESCALE_SH    = 8;
  localparam int INV_GAIN       = 39797;
  localparam int GAIN_W         = 16;
  localparam int SPLIT          = 22;
  localparam int FW             = 17;
  localparam int YAW_W          = 16;
  localparam int PITCH_W        = 15;
  localparam int ROLL_W         = 16;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(5898240);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(11796480);
  localparam logic signed [FW-1:0] LIM_WIDE  = FW'(23040);
  localparam logic signed [FW-1:0] LIM_PITCH = FW'(11520);

  typedef struct packed {
    logic xz;
    logic yz;
    logic xneg;
    logic yneg;
  } cflags_t;

  function automatic int atan_q16(input int s);
    int a;
    begin
      case (s)
        0: a = 2949120;
        1: a = 1740967;
        2: a = 919879;
        3: a = 466945;
        4: a = 234379;
        5: a = 117304;
        6: a = 58666;
        7: a = 29335;
        8: a = 14668;
        9: a = 7334;
        10: a = 3667;
        11: a = 1833;
        12: a = 917;
        13: a = 458;
        14: a = 229;
        15: a = 115;
        16: a = 57;
        17: a = 29;
        18: a = 14;
        19: a = 7;
        default: a = 0;
      endcase
      return a;
    end
  endfunction

  // round half up to 7 fraction bits, then clamp
  function automatic logic signed [FW-1:0] to_field(input logic signed [ZW-1:0] ang,
                                                    input logic signed [FW-1:0] lim);
    logic signed [ZW-1:0] t;
    logic signed [FW-1:0] v;
    begin
      t = ang + ZW'(256);
      v = FW'(t >>> 9);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
    end
  endfunction

endpackage

// ----- hw/rtl/q2e_delay.sv -----
// ----------------------------------------------------------------------------
// q2e_delay
// Enabled shift line that keeps side data aligned with the CORDIC stages.
// ----------------------------------------------------------------------------
module q2e_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
    end
  end

  for (genvar t = 1; t < DEPTH; t++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[t] <= tap_r[t-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// ----- hw/rtl/q2e_cordic.sv -----
// ----------------------------------------------------------------------------
// q2e_cordic
// Unrolled vectoring CORDIC: one pre-rotation stage, then one step per stage.
// ----------------------------------------------------------------------------
module q2e_cordic (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [q2e_pkg::CW-1:0]    x_in,
  input  logic signed [q2e_pkg::CW-1:0]    y_in,
  output logic signed [q2e_pkg::CW-1:0]    x_out,
  output logic signed [q2e_pkg::ZW-1:0]    ang_out
);

  localparam int N = q2e_pkg::STEPS;

  logic signed [q2e_pkg::CW-1:0] x_r [N+1];
  logic signed [q2e_pkg::CW-1:0] y_r [N+1];
  logic signed [q2e_pkg::ZW-1:0] z_r [N+1];
  q2e_pkg::cflags_t              f_r [N+1];

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      f_r[0] <= '{xz: (x_in == '0), yz: (y_in == '0), xneg: x_in[q2e_pkg::CW-1],
                  yneg: y_in[q2e_pkg::CW-1]};
      x_r[0] <= x_in[q2e_pkg::CW-1] ? -x_in : x_in;
      y_r[0] <= x_in[q2e_pkg::CW-1] ? -y_in : y_in;
      z_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    localparam logic signed [q2e_pkg::ZW-1:0] A = q2e_pkg::ZW'(q2e_pkg::atan_q16(s));
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[s] > 0) begin
          x_r[s+1] <= x_r[s] + (y_r[s] >>> s);
          y_r[s+1] <= y_r[s] - (x_r[s] >>> s);
          z_r[s+1] <= z_r[s] + A;
        end else begin
          x_r[s+1] <= x_r[s] - (y_r[s] >>> s);
          y_r[s+1] <= y_r[s] + (x_r[s] >>> s);
          z_r[s+1] <= z_r[s] - A;
        end
        f_r[s+1] <= f_r[s];
      end
    end
  end

  assign x_out = x_r[N];

  always_comb begin
    if (f_r[N].yz) begin
      ang_out = f_r[N].xneg ? q2e_pkg::DEG180 : '0;
    end else if (f_r[N].xz) begin
      ang_out = f_r[N].yneg ? -q2e_pkg::DEG90 : q2e_pkg::DEG90;
    end else if (f_r[N].xneg) begin
      ang_out = z_r[N] + (f_r[N].yneg ? -q2e_pkg::DEG180 : q2e_pkg::DEG180);
    end else begin
      ang_out = z_r[N];
    end
  end

endmodule

// ----- hw/rtl/q2e_front.sv -----
// ----------------------------------------------------------------------------
// q2e_front
// Normalize the quaternion, form the products and the CORDIC input vectors.
// ----------------------------------------------------------------------------
module q2e_front #(
  parameter int QW = q2e_pkg::QUAT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [4*QW-1:0]               q_in,
  output logic signed [q2e_pkg::CW-1:0] yaw_x,
  output logic signed [q2e_pkg::CW-1:0] yaw_y,
  output logic signed [q2e_pkg::CW-1:0] roll_x,
  output logic signed [q2e_pkg::CW-1:0] roll_y,
  output logic signed [q2e_pkg::CW-1:0] pitch_y,
  output logic                          zero
);

  localparam int PW  = $clog2(QW);
  localparam int EXT = QW + q2e_pkg::NORM_W;
  localparam int NW  = q2e_pkg::NORM_W;
  localparam int PR  = q2e_pkg::PROD_W;
  localparam int CW  = q2e_pkg::CW;
  localparam int SH  = q2e_pkg::PRESCALE_SH;

  // stage 1: magnitude OR and top bit position
  logic [QW-1:0] mag [4];
  logic [QW-1:0] orv;
  logic [PW-1:0] p;
  logic [QW-1:0] q1_r [4];
  logic [PW-1:0] p_r;
  logic          zero1_r;

  always_comb begin
    orv = '0;
    p   = '0;
    for (int n = 0; n < 4; n++) begin
      mag[n] = q_in[n*QW+QW-1] ? (~q_in[n*QW +: QW] + 1'b1) : q_in[n*QW +: QW];
      orv    = orv | mag[n];
    end
    for (int b = 0; b < QW; b++) begin
      if (orv[b]) p = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 4; n++) q1_r[n] <= q_in[n*QW +: QW];
      p_r     <= p;
      zero1_r <= (orv == '0);
    end
  end

  // stage 2: common shift so the top magnitude bit lands at 14
  logic [5:0]            pe;
  logic signed [EXT-1:0] qx [4];
  logic signed [EXT-1:0] qs [4];
  logic signed [NW-1:0]  qn_r [4];
  logic                  zero2_r;

  always_comb begin
    pe = 6'(p_r);
    for (int n = 0; n < 4; n++) begin
      qx[n] = {{NW{q1_r[n][QW-1]}}, q1_r[n]};
      if (pe >= 6'd14) qs[n] = qx[n] >>> (pe - 6'd14);
      else             qs[n] = qx[n] <<< (6'd14 - pe);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 4; n++) qn_r[n] <= qs[n][NW-1:0];
      zero2_r <= zero1_r;
    end
  end

  // stage 3: products (r = 0, i = 1, j = 2, k = 3)
  logic signed [PR-1:0] ii_r, jj_r, kk_r, rr_r, ij_r, kr_r, ik_r, jr_r, jk_r, ir_r;
  logic                 zero3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ii_r    <= qn_r[1] * qn_r[1];
      jj_r    <= qn_r[2] * qn_r[2];
      kk_r    <= qn_r[3] * qn_r[3];
      rr_r    <= qn_r[0] * qn_r[0];
      ij_r    <= qn_r[1] * qn_r[2];
      kr_r    <= qn_r[3] * qn_r[0];
      ik_r    <= qn_r[1] * qn_r[3];
      jr_r    <= qn_r[2] * qn_r[0];
      jk_r    <= qn_r[2] * qn_r[3];
      ir_r    <= qn_r[1] * qn_r[0];
      zero3_r <= zero2_r;
    end
  end

  // stage 4: sums, the cross-product sums doubled, all prescaled
  logic signed [CW-1:0] yx_r, yy_r, rx_r, ry_r, py_r;
  logic                 zero4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yx_r <= (CW'(ii_r) - CW'(jj_r) - CW'(kk_r) + CW'(rr_r)) <<< SH;
      yy_r <= (CW'(ij_r) + CW'(kr_r)) <<< (SH + 1);
      rx_r <= (CW'(rr_r) + CW'(kk_r) - CW'(ii_r) - CW'(jj_r)) <<< SH;
      ry_r <= (CW'(jk_r) + CW'(ir_r)) <<< (SH + 1);
      py_r <= (CW'(jr_r) - CW'(ik_r)) <<< (SH + 1);
      zero4_r <= zero3_r;
    end
  end

  assign yaw_x   = yx_r;
  assign yaw_y   = yy_r;
  assign roll_x  = rx_r;
  assign roll_y  = ry_r;
  assign pitch_y = py_r;
  assign zero    = zero4_r;

endmodule

// ----- hw/rtl/quaternion_to_euler_angles_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Streaming ZYX quaternion to yaw, pitch and roll converter.
// ----------------------------------------------------------------------------
// One quaternion word is taken every clock cycle unless the pipeline holds;
// its angles pass 4 front stages, a 21-stage yaw/roll CORDIC, 2 gain stages,
// a 21-stage pitch CORDIC and the output register. Throughput is one word per
// cycle while not held, set by the fully unrolled CORDIC pipelines. When
// out_tready is low and out_tvalid high, the whole pipeline holds and in_tready
// drops with it. A zero quaternion returns zero angles with out_tuser set.
module quaternion_to_euler_angles_core #(
  parameter int QUAT_WIDTH = q2e_pkg::QUAT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // q_real, q_i, q_j, q_k
  input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // yaw_deg, pitch_deg, roll_deg
  output logic [47:0]                         out_tdata,
  // degenerate
  output logic [0:0]                          out_tuser
);

  localparam int CW  = q2e_pkg::CW;
  localparam int ZW  = q2e_pkg::ZW;
  localparam int N1  = q2e_pkg::STEPS + 1;
  localparam int LAT = 4 + N1 + 2 + N1 + 1;
  localparam int SP  = q2e_pkg::SPLIT;
  localparam int GW  = q2e_pkg::GAIN_W;
  localparam logic [GW-1:0] GAIN = GW'(q2e_pkg::INV_GAIN);

  logic en;
  logic [LAT-1:0] vld_r;

  assign en        = out_tready || !vld_r[LAT-1];
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  logic signed [CW-1:0] yx, yy, rx, ry, py;
  logic                 zero;

  q2e_front #(.QW(QUAT_WIDTH)) u_front (
    .clk(clk), .en(en), .q_in(in_tdata[4*QUAT_WIDTH-1:0]),
    .yaw_x(yx), .yaw_y(yy), .roll_x(rx), .roll_y(ry), .pitch_y(py), .zero(zero)
  );

  logic signed [CW-1:0] yaw_xf, roll_xf, pitch_xf;
  logic signed [ZW-1:0] yaw_ang, roll_ang, pitch_ang;

  q2e_cordic u_cordic_yaw (
    .clk(clk), .en(en), .x_in(yx), .y_in(yy), .x_out(yaw_xf), .ang_out(yaw_ang)
  );

  q2e_cordic u_cordic_roll (
    .clk(clk), .en(en), .x_in(rx), .y_in(ry), .x_out(roll_xf), .ang_out(roll_ang)
  );

  // yaw vector length times inverse gain, split into two partial products
  logic [SP+GW-1:0]        plo_r;
  logic [CW-SP+GW-1:0]     phi_r;
  logic signed [CW-1:0]    h_r;
  logic [CW+GW-1:0]        hsum;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= yaw_xf[SP-1:0] * GAIN;
      phi_r <= yaw_xf[CW-1:SP] * GAIN;
    end
  end

  assign hsum = {phi_r, {SP{1'b0}}} + (CW+GW)'(plo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= hsum[CW+GW-1:GW];
    end
  end

  logic signed [CW-1:0] py_d;

  q2e_delay #(.W(CW), .DEPTH(N1 + 2)) u_dly_py (.clk(clk), .en(en), .d(py), .q(py_d));

  q2e_cordic u_cordic_pitch (
    .clk(clk), .en(en), .x_in(h_r), .y_in(py_d), .x_out(pitch_xf), .ang_out(pitch_ang)
  );

  logic signed [ZW-1:0] yaw_d, roll_d;
  logic                 zero_d;

  q2e_delay #(.W(ZW), .DEPTH(N1 + 2)) u_dly_yaw (
    .clk(clk), .en(en), .d(yaw_ang), .q(yaw_d)
  );
  q2e_delay #(.W(ZW), .DEPTH(N1 + 2)) u_dly_roll (
    .clk(clk), .en(en), .d(roll_ang), .q(roll_d)
  );
  q2e_delay #(.W(1), .DEPTH(N1 + 2 + N1)) u_dly_zero (
    .clk(clk), .en(en), .d(zero), .q(zero_d)
  );

  logic signed [q2e_pkg::FW-1:0] yaw_f, pitch_f, roll_f;
  logic [47:0] data_r;
  logic        deg_r;

  assign yaw_f   = q2e_pkg::to_field(yaw_d, q2e_pkg::LIM_WIDE);
  assign pitch_f = q2e_pkg::to_field(pitch_ang, q2e_pkg::LIM_PITCH);
  assign roll_f  = q2e_pkg::to_field(roll_d, q2e_pkg::LIM_WIDE);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_d) begin
        data_r <= '0;
      end else begin
        data_r <= {1'b0, roll_f[q2e_pkg::ROLL_W-1:0], pitch_f[q2e_pkg::PITCH_W-1:0],
                   yaw_f[q2e_pkg::YAW_W-1:0]};
      end
      deg_r <= zero_d;
    end
  end

  assign out_tvalid   = vld_r[LAT-1];
  assign out_tdata    = data_r;
  assign out_tuser[0] = deg_r;

`ifndef SYNTH
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate word carries nonzero angles");

  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:16]) <= 15'sd11520) &&
                   ($signed(out_tdata[30:16]) >= -15'sd11520))
    else $error("pitch out of range");

  a_yaw_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd23040) &&
                   ($signed(out_tdata[15:0]) >= -16'sd23040))
    else $error("yaw out of range");

  a_roll_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[46:31]) <= 16'sd23040) &&
                   ($signed(out_tdata[46:31]) >= -16'sd23040) && !out_tdata[47])
    else $error("roll out of range");
`endif

endmodule

// ----- tb/quaternion_to_euler_angles_core_tb.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core_tb
// Streams quaternions through the converter and checks yaw, pitch, roll and
// the zero-norm flag of every output word against a fixed-point CORDIC
// predictor, under random idling on the input and output sides.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QW         = 16;
  localparam int IN_W       = ((4*QW+7)/8)*8;
  localparam int N_RANDOM   = 1100;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_CYC  = 60;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic               degen;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0] out_tuser;

  quaternion_to_euler_angles_core #(.QUAT_WIDTH(QW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  logic [IN_W-1:0] quat_queue[$];
  angles_t angles_due[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int words_checked = 0;
  int degen_seen = 0;
  longint cycles = 0;

  localparam longint ATAN_Q16[20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  // arithmetic shift on a signed longint floors, as wanted
  function automatic void cordic_atan2(input longint x, input longint y,
                                       output longint ang, output longint mag);
    longint x0, y0, base, z, nx, ny;
    x0 = x; y0 = y; base = 0; z = 0;
    if (x < 0) begin
      base = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    for (int s = 0; s < 20; s++) begin
      if (y > 0) begin
        nx = x + (y >>> s);
        ny = y - (x >>> s);
        z += ATAN_Q16[s];
      end else begin
        nx = x - (y >>> s);
        ny = y + (x >>> s);
        z -= ATAN_Q16[s];
      end
      x = nx;
      y = ny;
    end
    mag = (x * 39797) >>> 16;
    if (y0 == 0) ang = (x0 >= 0) ? 0 : 64'sd11796480;
    else if (x0 == 0) ang = (y0 > 0) ? 64'sd5898240 : -64'sd5898240;
    else ang = base + z;
  endfunction

  function automatic longint round_clamp(input longint ang, input longint lim);
    longint v;
    v = (ang + 256) >>> 9;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic angles_t predict_angles(input logic [IN_W-1:0] w);
    angles_t a;
    longint q[4];
    longint m, r, i, j, k, yaw, pitch, roll, h, hr;
    for (int n = 0; n < 4; n++) q[n] = longint'($signed(w[n*QW +: QW]));
    m = 0;
    foreach (q[n]) if ((q[n] < 0 ? -q[n] : q[n]) > m) m = q[n] < 0 ? -q[n] : q[n];
    a = '0;
    if (m == 0) begin
      a.degen = 1'b1;
      return a;
    end
    while (m >= 32768) begin
      m = 0;
      for (int n = 0; n < 4; n++) begin
        q[n] = q[n] >>> 1;
        if ((q[n] < 0 ? -q[n] : q[n]) > m) m = q[n] < 0 ? -q[n] : q[n];
      end
    end
    while (m < 16384) begin
      for (int n = 0; n < 4; n++) q[n] *= 2;
      m *= 2;
    end
    r = q[0]; i = q[1]; j = q[2]; k = q[3];
    cordic_atan2((i*i - j*j - k*k + r*r) * 256, 2*(i*j + k*r) * 256, yaw, h);
    cordic_atan2(h, -2*(i*k - j*r) * 256, pitch, hr);
    cordic_atan2((-i*i - j*j + k*k + r*r) * 256, 2*(j*k + i*r) * 256, roll, hr);
    a.yaw   = 16'(round_clamp(yaw, 23040));
    a.pitch = 15'(round_clamp(pitch, 11520));
    a.roll  = 16'(round_clamp(roll, 23040));
    return a;
  endfunction

  function automatic logic [IN_W-1:0] pack_quat(input int r, input int i,
                                               input int j, input int k);
    return {16'(k), 16'(j), 16'(i), 16'(r)};
  endfunction

  // feeder: present the next word, advance on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (quat_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata <= quat_queue[0];
          in_tvalid <= 1'b1;
          angles_due.push_back(predict_angles(quat_queue[0]));
          void'(quat_queue.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        angles_t got, want;
        got = {out_tdata[15:0], out_tdata[30:16], out_tdata[46:31], out_tuser[0]};
        if (angles_due.size() == 0) begin
          $display("%0t: unexpected word, got %h", $time, got);
          errors++;
        end else begin
          want = angles_due.pop_front();
          words_checked++;
          if (want.degen) degen_seen++;
          if (got.yaw !== want.yaw || got.pitch !== want.pitch ||
              got.roll !== want.roll || got.degen !== want.degen) begin
            $display("%0t: mismatch expected yaw %0d pitch %0d roll %0d degen %0b",
                     $time, want.yaw, want.pitch, want.roll, want.degen);
            $display("%0t:          actual   yaw %0d pitch %0d roll %0d degen %0b",
                     $time, got.yaw, got.pitch, got.roll, got.degen);
            errors++;
          end
          if (out_tdata[47] !== 1'b0) begin
            $display("%0t: pad bit expected 0, actual %b", $time, out_tdata[47]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    int mode;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(9);
      if (mode < 6)
        quat_queue.push_back({$urandom(), $urandom()});
      else if (mode < 8)
        quat_queue.push_back(pack_quat($urandom_range(65535) % 64 - 32,
                                       $urandom_range(63) - 32,
                                       $urandom_range(63) - 32,
                                       $urandom_range(63) - 32));
      else if (mode < 9)
        quat_queue.push_back(pack_quat(($urandom_range(1) ? 32767 : -32768),
                                       $urandom_range(3) == 0 ? 0 : $urandom(),
                                       $urandom_range(3) == 0 ? 0 : $urandom(),
                                       $urandom_range(3) == 0 ? 0 : $urandom()));
      else
        quat_queue.push_back(pack_quat(0, 0, 0, 0));
    end
    while (quat_queue.size() > 0 || angles_due.size() > 0) @(posedge clk);
  endtask

  initial begin
    // directed: zero, axes, extremes, gimbal-lock pitch, unnormalized
    quat_queue.push_back(pack_quat(0, 0, 0, 0));
    quat_queue.push_back(pack_quat(16384, 0, 0, 0));
    quat_queue.push_back(pack_quat(-16384, 0, 0, 0));
    quat_queue.push_back(pack_quat(0, 16384, 0, 0));
    quat_queue.push_back(pack_quat(0, 0, 16384, 0));
    quat_queue.push_back(pack_quat(0, 0, 0, 16384));
    quat_queue.push_back(pack_quat(0, 0, 0, -16384));
    quat_queue.push_back(pack_quat(11585, 0, 11585, 0));
    quat_queue.push_back(pack_quat(11585, 0, -11585, 0));
    quat_queue.push_back(pack_quat(11585, 11585, 0, 0));
    quat_queue.push_back(pack_quat(11585, 0, 0, 11585));
    quat_queue.push_back(pack_quat(-32768, -32768, -32768, -32768));
    quat_queue.push_back(pack_quat(32767, 32767, 32767, 32767));
    quat_queue.push_back(pack_quat(32767, -32768, 32767, -32768));
    quat_queue.push_back(pack_quat(1, 0, 0, 0));
    quat_queue.push_back(pack_quat(-1, 0, 0, 0));
    quat_queue.push_back(pack_quat(0, 0, 0, -1));
    quat_queue.push_back(pack_quat(1, 1, 1, 1));
    quat_queue.push_back(pack_quat(3, -1, 2, 0));
    quat_queue.push_back(pack_quat(8192, 8192, 8192, 8192));
    quat_queue.push_back(pack_quat(-32768, 0, 0, 0));
    quat_queue.push_back(pack_quat(0, -32768, 32767, 0));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_phase(0, 0, 0);
    run_phase(20, 58, 370);
    run_phase(58, 20, 370);
    run_phase(0, 0, N_RANDOM - 740);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("checked %0d output words, %0d with zero norm, over %0d cycles",
             words_checked, degen_seen, cycles);
    if (errors == 0 && angles_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
